// ===== rtl/gsec_pkg.sv =====
// Shared types, constants and kernel tables for the edge-clamped Gaussian smoother.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package gsec_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int HALF_MAX    = 10;
  localparam int WIN_DEPTH   = 2 * HALF_MAX + 1;
  localparam int HW_NARROW   = 4;
  localparam int HW_WIDE     = 10;
  localparam int IDX_BITS    = $clog2(HALF_MAX + 1);
  localparam int CNT_BITS    = 4;
  localparam logic [CNT_BITS-1:0] SEEN_MAX = CNT_BITS'(15);

  localparam int TAP_BITS    = 12;
  localparam int PAIR_BITS   = SAMPLE_BITS + 1;
  // |weighted sum| <= 2^23 * 7471 < 2^36
  localparam int ACC_BITS    = 37;
  localparam int MAG_BITS    = ACC_BITS - 1;

  localparam int NORM_BITS   = 13;
  localparam int NORM_NARROW = 7471;
  localparam int NORM_WIDE   = 1945;

  // floor(2^MAG_BITS / norm); estimate is exact or one short
  localparam int REC_BITS    = 26;
  localparam logic [REC_BITS-1:0] REC_NARROW =
    REC_BITS'((64'd1 << MAG_BITS) / NORM_NARROW);
  localparam logic [REC_BITS-1:0] REC_WIDE =
    REC_BITS'((64'd1 << MAG_BITS) / NORM_WIDE);
  localparam int SPLIT       = MAG_BITS / 2;
  localparam int PP_BITS     = SPLIT + REC_BITS;
  localparam int FULL_BITS   = MAG_BITS + REC_BITS;
  localparam int QUO_BITS    = SAMPLE_BITS + 1;
  localparam int REM_BITS    = NORM_BITS + 1;

  localparam int SAT_HI = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SAT_LO = -(2 ** (SAMPLE_BITS - 1));

  typedef enum logic {
    MODE_NARROW = 1'b0,
    MODE_WIDE   = 1'b1
  } mode_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  function automatic logic [TAP_BITS-1:0] tap_weight(mode_t m, logic [IDX_BITS-1:0] a);
    logic [TAP_BITS-1:0] w;
    w = '0;
    if (m == MODE_WIDE) begin
      case (a)
        0:       w = 12'd259;
        1:       w = 12'd245;
        2:       w = 12'd207;
        3:       w = 12'd157;
        4:       w = 12'd106;
        5:       w = 12'd65;
        6:       w = 12'd35;
        7:       w = 12'd17;
        8:       w = 12'd7;
        9:       w = 12'd3;
        10:      w = 12'd1;
        default: w = '0;
      endcase
    end else begin
      case (a)
        0:       w = 12'd2981;
        1:       w = 12'd1808;
        2:       w = 12'd403;
        3:       w = 12'd33;
        4:       w = 12'd1;
        default: w = '0;
      endcase
    end
    return w;
  endfunction

  function automatic logic [NORM_BITS-1:0] norm_of(mode_t m);
    return (m == MODE_WIDE) ? NORM_BITS'(NORM_WIDE) : NORM_BITS'(NORM_NARROW);
  endfunction

  function automatic logic [REC_BITS-1:0] recip_of(mode_t m);
    return (m == MODE_WIDE) ? REC_WIDE : REC_NARROW;
  endfunction

  function automatic logic [CNT_BITS-1:0] half_width(mode_t m);
    return (m == MODE_WIDE) ? CNT_BITS'(HW_WIDE) : CNT_BITS'(HW_NARROW);
  endfunction

endpackage

// ===== rtl/gsec_if.sv =====
// Channel interfaces: sample input, smoothed output and mode register write.
// Depends on gsec_pkg.
interface gsec_in_if;
  logic               valid;
  logic               ready;
  gsec_pkg::sample_t  sample;
  logic               last_sample;
  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface gsec_out_if;
  logic               valid;
  logic               ready;
  gsec_pkg::sample_t  smoothed;
  logic               last_result;
  modport source (output valid, output smoothed, output last_result, input ready);
  modport sink   (input valid, input smoothed, input last_result, output ready);
endinterface

interface gsec_cfg_if;
  logic valid;
  logic ready;
  logic smoothing_mode;
  modport source (output valid, output smoothing_mode, input ready);
  modport sink   (input valid, input smoothing_mode, output ready);
endinterface

// ===== rtl/gaussian_smoother_edge_clamp_top.sv =====
// Edge-clamped Gaussian smoother: 9-tap (sigma 1) or 21-tap (sigma 3) kernel.
// Throughput: one sample per cycle while the output does not stall; a last sample then holds
// the input off while the window is flushed with the replicated end sample, one position
// at a time up to the half-width (4 or 10).
// Reset (rst, synchronous, active high) clears control, pipeline valids and the mode (0).
// Depends on gsec_pkg, gsec_if, gsec_mac, gsec_div.
module gaussian_smoother_edge_clamp_top (
  input logic       clk,
  input logic       rst,
  gsec_cfg_if.sink  cfg,
  gsec_in_if.sink   samples,
  gsec_out_if.source results
);
  gsec_pkg::mode_t   mode;
  gsec_pkg::sample_t window [gsec_pkg::WIN_DEPTH];
  gsec_pkg::sample_t push_val;

  logic [gsec_pkg::CNT_BITS-1:0] seen, seen_next, flush_cnt, flush_cnt_next, hw;
  logic in_seq, in_seq_next;
  logic load0, accept, flush_step, mac_ready, div_ready;

  gsec_pkg::tag_t tag0, tag0_next, mac_tag, div_tag;
  gsec_pkg::acc_t mac_sum;

  assign hw            = gsec_pkg::half_width(mode);
  assign load0         = !tag0.valid || mac_ready;
  assign samples.ready = load0 && (flush_cnt == '0);
  assign accept        = samples.valid && samples.ready;
  assign flush_step    = load0 && (flush_cnt != '0);
  assign cfg.ready     = 1'b1;
  assign push_val      = accept ? samples.sample : window[0];

  always_comb begin
    seen_next      = seen;
    in_seq_next    = in_seq;
    flush_cnt_next = flush_cnt;
    tag0_next      = tag0;
    if (load0) tag0_next = '{valid: 1'b0, last: 1'b0};
    if (accept) begin
      if (!in_seq) begin
        seen_next = gsec_pkg::CNT_BITS'(1);
      end else if (seen != gsec_pkg::SEEN_MAX) begin
        seen_next = seen + 1'b1;
      end
      tag0_next.valid = seen_next > hw;
      tag0_next.last  = 1'b0;
      in_seq_next     = !samples.last_sample;
      if (samples.last_sample) flush_cnt_next = gsec_pkg::CNT_BITS'(1);
    end else if (flush_step) begin
      // pending positions after the end; the final one always emits
      tag0_next.valid = ({1'b0, flush_cnt} + {1'b0, seen}) > {1'b0, hw};
      tag0_next.last  = (flush_cnt == hw);
      flush_cnt_next  = (flush_cnt == hw) ? '0 : flush_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= gsec_pkg::MODE_NARROW;
      seen      <= '0;
      in_seq    <= 1'b0;
      flush_cnt <= '0;
      tag0      <= '{valid: 1'b0, last: 1'b0};
    end else begin
      if (cfg.valid && cfg.ready) mode <= gsec_pkg::mode_t'(cfg.smoothing_mode);
      seen      <= seen_next;
      in_seq    <= in_seq_next;
      flush_cnt <= flush_cnt_next;
      tag0      <= tag0_next;
    end
  end

  // first sample of a sequence replicates across the window (left-edge clamp)
  always_ff @(posedge clk) begin
    if (accept && !in_seq) begin
      for (int i = 0; i < gsec_pkg::WIN_DEPTH; i++) window[i] <= samples.sample;
    end else if (accept || flush_step) begin
      for (int i = gsec_pkg::WIN_DEPTH - 1; i > 0; i--) window[i] <= window[i-1];
      window[0] <= push_val;
    end
  end

  gsec_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .tag_in   (tag0),
    .ready_up (mac_ready),
    .win      (window),
    .tag_out  (mac_tag),
    .ready_dn (div_ready),
    .sum      (mac_sum)
  );

  gsec_div u_div (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .tag_in   (mac_tag),
    .sum      (mac_sum),
    .ready_up (div_ready),
    .tag_out  (div_tag),
    .smoothed (results.smoothed),
    .ready_dn (results.ready)
  );

  assign results.valid       = div_tag.valid;
  assign results.last_result = div_tag.last;

  a_hold_stage0: assert property (@(posedge clk) disable iff (rst)
    (tag0.valid && !mac_ready) |=> tag0.valid)
    else $error("stage-0 word dropped while stalled");

  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    flush_cnt <= hw)
    else $error("flush counter beyond half-width");

  a_flush_end_last: assert property (@(posedge clk) disable iff (rst)
    (flush_step && (flush_cnt == hw)) |=> (tag0.valid && tag0.last))
    else $error("end of flush did not emit the marked final word");

  a_accept_unmarked: assert property (@(posedge clk) disable iff (rst)
    accept |=> !tag0.last)
    else $error("accepted sample produced a marked word");

endmodule

// ===== rtl/gsec_mac.sv =====
// Kernel multiply-accumulate: symmetric pair sums, tap products, adder tree.
// Four stages with valid/ready per stage. Depends on gsec_pkg.
module gsec_mac (
  input  logic              clk,
  input  logic              rst,
  input  gsec_pkg::mode_t   mode,
  input  gsec_pkg::tag_t    tag_in,
  output logic              ready_up,
  input  gsec_pkg::sample_t win [gsec_pkg::WIN_DEPTH],
  output gsec_pkg::tag_t    tag_out,
  input  logic              ready_dn,
  output gsec_pkg::acc_t    sum
);
  localparam int NS = 4;

  logic [NS-1:0] v, lst, ld, v_prev, lst_prev;

  logic signed [gsec_pkg::PAIR_BITS-1:0] pair_next [gsec_pkg::HALF_MAX+1];
  logic signed [gsec_pkg::PAIR_BITS-1:0] pair      [gsec_pkg::HALF_MAX+1];
  gsec_pkg::acc_t prod [gsec_pkg::HALF_MAX+1];
  gsec_pkg::acc_t grp  [3];

  assign v_prev   = {v[NS-2:0], tag_in.valid};
  assign lst_prev = {lst[NS-2:0], tag_in.last};

  // a stage loads when it is empty or its word moves on
  always_comb begin
    ld[NS-1] = !v[NS-1] || ready_dn;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !v[i] || ld[i+1];
    end
  end

  assign ready_up = ld[0];
  assign tag_out  = '{valid: v[NS-1], last: lst[NS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (ld[i]) v[i] <= v_prev[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (ld[i]) lst[i] <= lst_prev[i];
    end
  end

  // the window centre sits at the half-width of the selected kernel
  always_comb begin
    for (int a = 0; a <= gsec_pkg::HALF_MAX; a++) begin
      pair_next[a] = '0;
    end
    if (mode == gsec_pkg::MODE_WIDE) begin
      pair_next[0] = gsec_pkg::PAIR_BITS'(win[gsec_pkg::HW_WIDE]);
      for (int a = 1; a <= gsec_pkg::HW_WIDE; a++) begin
        pair_next[a] = gsec_pkg::PAIR_BITS'(win[gsec_pkg::HW_WIDE - a])
                     + gsec_pkg::PAIR_BITS'(win[gsec_pkg::HW_WIDE + a]);
      end
    end else begin
      pair_next[0] = gsec_pkg::PAIR_BITS'(win[gsec_pkg::HW_NARROW]);
      for (int a = 1; a <= gsec_pkg::HW_NARROW; a++) begin
        pair_next[a] = gsec_pkg::PAIR_BITS'(win[gsec_pkg::HW_NARROW - a])
                     + gsec_pkg::PAIR_BITS'(win[gsec_pkg::HW_NARROW + a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      for (int a = 0; a <= gsec_pkg::HALF_MAX; a++) pair[a] <= pair_next[a];
    end
    if (ld[1]) begin
      for (int a = 0; a <= gsec_pkg::HALF_MAX; a++) begin
        prod[a] <= gsec_pkg::ACC_BITS'(pair[a] * $signed({1'b0,
                     gsec_pkg::tap_weight(mode, gsec_pkg::IDX_BITS'(a))}));
      end
    end
    if (ld[2]) begin
      grp[0] <= prod[0] + prod[1] + prod[2] + prod[3];
      grp[1] <= prod[4] + prod[5] + prod[6] + prod[7];
      grp[2] <= prod[8] + prod[9] + prod[10];
    end
    if (ld[3]) begin
      sum <= grp[0] + grp[1] + grp[2];
    end
  end

endmodule

// ===== rtl/gsec_div.sv =====
// Normalization: round-half-away division by the tap sum, saturation, output register.
// Reciprocal multiply with one correction step, five stages. Depends on gsec_pkg.
module gsec_div (
  input  logic              clk,
  input  logic              rst,
  input  gsec_pkg::mode_t   mode,
  input  gsec_pkg::tag_t    tag_in,
  input  gsec_pkg::acc_t    sum,
  output logic              ready_up,
  output gsec_pkg::tag_t    tag_out,
  output gsec_pkg::sample_t smoothed,
  input  logic              ready_dn
);
  localparam int NS = 5;

  logic [NS-1:0] v, lst, ld, v_prev, lst_prev;

  logic                               neg5, neg6, neg7, neg8;
  logic [gsec_pkg::MAG_BITS-1:0]      mag5, mag6, mag7;
  logic [gsec_pkg::PP_BITS-1:0]       ph, pl;
  logic [gsec_pkg::QUO_BITS-1:0]      q7, q8, qf;
  logic [gsec_pkg::REM_BITS-1:0]      r8;
  logic [gsec_pkg::NORM_BITS-1:0]     norm;
  gsec_pkg::acc_t                     abs_sum;
  logic [gsec_pkg::FULL_BITS-1:0]     full;
  logic signed [gsec_pkg::QUO_BITS:0] val;
  gsec_pkg::sample_t                  sat;

  assign v_prev   = {v[NS-2:0], tag_in.valid};
  assign lst_prev = {lst[NS-2:0], tag_in.last};

  always_comb begin
    ld[NS-1] = !v[NS-1] || ready_dn;
    for (int i = NS - 2; i >= 0; i--) begin
      ld[i] = !v[i] || ld[i+1];
    end
  end

  assign ready_up = ld[0];
  assign tag_out  = '{valid: v[NS-1], last: lst[NS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (ld[i]) v[i] <= v_prev[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (ld[i]) lst[i] <= lst_prev[i];
    end
  end

  assign norm    = gsec_pkg::norm_of(mode);
  assign abs_sum = sum[gsec_pkg::ACC_BITS-1] ? -sum : sum;
  assign full    = (gsec_pkg::FULL_BITS'(ph) << gsec_pkg::SPLIT) + gsec_pkg::FULL_BITS'(pl);

  // estimate may be one short; remainder >= norm bumps it
  always_comb begin
    qf  = q8 + gsec_pkg::QUO_BITS'(r8 >= gsec_pkg::REM_BITS'(norm));
    val = neg8 ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
    if (val > (gsec_pkg::QUO_BITS + 1)'(gsec_pkg::SAT_HI)) begin
      sat = gsec_pkg::SAMPLE_BITS'(gsec_pkg::SAT_HI);
    end else if (val < (gsec_pkg::QUO_BITS + 1)'(gsec_pkg::SAT_LO)) begin
      sat = gsec_pkg::SAMPLE_BITS'(gsec_pkg::SAT_LO);
    end else begin
      sat = gsec_pkg::SAMPLE_BITS'(val);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      neg5 <= sum[gsec_pkg::ACC_BITS-1];
      mag5 <= gsec_pkg::MAG_BITS'(abs_sum) + gsec_pkg::MAG_BITS'(norm >> 1);
    end
    if (ld[1]) begin
      ph   <= gsec_pkg::PP_BITS'(mag5[gsec_pkg::MAG_BITS-1:gsec_pkg::SPLIT]
                                 * gsec_pkg::recip_of(mode));
      pl   <= gsec_pkg::PP_BITS'(mag5[gsec_pkg::SPLIT-1:0] * gsec_pkg::recip_of(mode));
      mag6 <= mag5;
      neg6 <= neg5;
    end
    if (ld[2]) begin
      q7   <= full[gsec_pkg::MAG_BITS +: gsec_pkg::QUO_BITS];
      mag7 <= mag6;
      neg7 <= neg6;
    end
    if (ld[3]) begin
      r8   <= gsec_pkg::REM_BITS'(mag7 - gsec_pkg::MAG_BITS'(q7 * norm));
      q8   <= q7;
      neg8 <= neg7;
    end
    if (ld[4]) begin
      smoothed <= sat;
    end
  end

endmodule

// ===== verif/tb_gaussian_smoother_edge_clamp_top.sv =====
// Testbench for gaussian_smoother_edge_clamp_top: drives sample sequences in both kernel
// modes with random gaps and stalls, and predicts every smoothed word in a scoreboard class.
// Depends on gsec_pkg, gsec_if and the smoother RTL.
module tb_gaussian_smoother_edge_clamp_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gsec_pkg::*;

  localparam int NARROW_TAPS [0:4]  = '{2981, 1808, 403, 33, 1};
  localparam int WIDE_TAPS   [0:10] = '{259, 245, 207, 157, 106, 65, 35, 17, 7, 3, 1};
  localparam int QUIET_CYCLES  = 20;
  localparam int TOTAL_SAMPLES = 320;
  localparam sample_t S_MAX = sample_t'(SAT_HI);
  localparam sample_t S_MIN = sample_t'(SAT_LO);

  typedef struct {
    sample_t smoothed;
    logic    is_last;
  } smoothed_word_t;

  class smoother_scoreboard;
    sample_t        window [WIN_DEPTH];
    int unsigned    seen;
    bit             open_seq;
    mode_t          mode;
    smoothed_word_t expected_words [$];
    int             errors;
    int             words_checked;

    function new();
      foreach (window[i]) window[i] = '0;
      seen = 0;
      open_seq = 0;
      mode = MODE_NARROW;
      errors = 0;
      words_checked = 0;
    endfunction

    function int tap_of(int a);
      return (mode == MODE_WIDE) ? WIDE_TAPS[a] : NARROW_TAPS[a];
    endfunction

    function void shift_in(sample_t x);
      for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = x;
    endfunction

    function void add_word(sample_t v, logic is_last);
      smoothed_word_t w;
      w.smoothed = v;
      w.is_last  = is_last;
      expected_words.insert(expected_words.size(), w);
    endfunction

    // Exact weighted sum over the window, divided by the tap sum with
    // round-half-away-from-zero, then clamped to the sample range.
    function sample_t smooth_point(int hw);
      longint acc, norm, mag, q, w;
      int a;
      acc = 0;
      norm = 0;
      for (int d = -hw; d <= hw; d++) begin
        a = (d < 0) ? -d : d;
        w = tap_of(a);
        acc += w * longint'(window[hw - d]);
        norm += w;
      end
      mag = (acc < 0) ? -acc : acc;
      q = (mag + norm / 2) / norm;
      if (acc < 0) q = -q;
      if (q > SAT_HI) q = SAT_HI;
      if (q < SAT_LO) q = SAT_LO;
      return sample_t'(q);
    endfunction

    function void note_sample(sample_t x, logic is_last);
      int hw;
      hw = (mode == MODE_WIDE) ? HW_WIDE : HW_NARROW;
      if (!open_seq) begin
        foreach (window[i]) window[i] = x;
        seen = 0;
        open_seq = 1;
      end else begin
        shift_in(x);
      end
      if (seen < 15) seen++;
      if (seen > hw) add_word(smooth_point(hw), 1'b0);
      if (is_last) begin
        // flush with the end sample replicated; the word at p == hw always exists
        for (int p = 1; p <= hw; p++) begin
          shift_in(x);
          if (p + seen > hw) add_word(smooth_point(hw), logic'(p == hw));
        end
        open_seq = 0;
        seen = 0;
      end
    endfunction

    function void check_result(sample_t smoothed, logic is_last);
      smoothed_word_t e;
      if (expected_words.size() == 0) begin
        $error("unexpected smoothed word: smoothed %0d, last_result %0b", smoothed, is_last);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      words_checked++;
      if (smoothed !== e.smoothed) begin
        $error("smoothed: expected %0d, actual %0d", e.smoothed, smoothed);
        errors++;
      end
      if (is_last !== e.is_last) begin
        $error("last_result: expected %0b, actual %0b", e.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic no_gaps;
  logic no_stalls;
  int   sent;
  int   sequences;
  int   mode_writes [2];

  gsec_cfg_if cfg_if ();
  gsec_in_if  samples_if ();
  gsec_out_if results_if ();

  smoother_scoreboard sb;

  gaussian_smoother_edge_clamp_top uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .samples (samples_if),
    .results (results_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(input sample_t s, input logic is_last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid       <= 1'b1;
    samples_if.sample      <= s;
    samples_if.last_sample <= is_last;
    do @(posedge clk); while (!samples_if.ready);
    sb.note_sample(s, is_last);
    sent++;
    if (is_last) sequences++;
  endtask

  // Lets every expected word drain, then covers the pipeline depth.
  task automatic wait_quiet();
    samples_if.valid <= 1'b0;
    while (sb.expected_words.size() > 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    cfg_if.valid          <= 1'b1;
    cfg_if.smoothing_mode <= m;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sb.mode = m;
    mode_writes[m]++;
  endtask

  // result sink: random stall before each word
  initial begin
    int stall;
    results_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_stalls ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      do @(posedge clk); while (!results_if.valid);
      sb.check_result(results_if.smoothed, results_if.last_result);
    end
  end

  initial begin
    int nseq, len;
    bit leave_open;
    sb = new();
    sent = 0;
    sequences = 0;
    mode_writes = '{0, 0};
    no_gaps = 1'b0;
    no_stalls = 1'b0;
    rst <= 1'b1;
    cfg_if.valid <= 1'b0;
    cfg_if.smoothing_mode <= MODE_NARROW;
    samples_if.valid <= 1'b0;
    samples_if.sample <= '0;
    samples_if.last_sample <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single-sample sequence, range extremes, mode change mid-sequence
    write_mode(MODE_NARROW);
    send_sample(S_MAX, 1'b1);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(sample_t'(0), 1'b0);
    send_sample(sample_t'(-1), 1'b0);
    send_sample(sample_t'(1), 1'b0);
    send_sample(S_MAX, 1'b1);
    send_sample(sample_t'(3), 1'b0);
    send_sample(sample_t'(100), 1'b0);
    send_sample(sample_t'(-100), 1'b0);
    wait_quiet();
    write_mode(MODE_WIDE);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MAX, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(S_MIN, 1'b0);
    send_sample(sample_t'(7), 1'b1);
    for (int i = 0; i < 6; i++) send_sample((i % 2) ? S_MAX : S_MIN, logic'(i == 5));

    // random phases: mostly complete sequences, some left open across a mode write
    while (sent < TOTAL_SAMPLES) begin
      wait_quiet();
      no_gaps   = ($urandom_range(0, 3) == 0);
      no_stalls = ($urandom_range(0, 3) == 0);
      write_mode(mode_t'($urandom_range(0, 1)));
      nseq = $urandom_range(1, 4);
      for (int s = 0; s < nseq; s++) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 14);
        leave_open = (s == nseq - 1) && ($urandom_range(0, 4) == 0);
        for (int i = 0; i < len; i++)
          send_sample(random_sample(), logic'(i == len - 1 && !leave_open));
      end
    end
    if (sb.open_seq) send_sample(random_sample(), 1'b1);

    wait_quiet();
    if (sb.expected_words.size() > 0) begin
      $error("%0d smoothed words never arrived", sb.expected_words.size());
      sb.errors++;
    end
    $display("Covered %0d samples in %0d sequences, %0d smoothed words checked",
             sent, sequences, sb.words_checked);
    $display("Mode writes: narrow kernel %0d, wide kernel %0d", mode_writes[0], mode_writes[1]);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gsec_pkg.sv
rtl/gsec_if.sv
rtl/gsec_mac.sv
rtl/gsec_div.sv
rtl/gaussian_smoother_edge_clamp_top.sv
verif/tb_gaussian_smoother_edge_clamp_top.sv
